// File: sv/lzwd_pkg.sv
package lzwd_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
  } out_item_t;

  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_PULL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_NEED     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_ACCEPTED = 3'd4;

  localparam int unsigned CODE_END    = 256;
  localparam int unsigned CODE_CLEAR  = 257;
  localparam int unsigned FIRST_WIDTH = 9;

  localparam logic [0:0] REG_OUT_LIMIT  = 1'b0;
  localparam logic [0:0] REG_SKIP_COUNT = 1'b1;

endpackage

// File: sv/lzw_variable_width_decoder_unit.sv
// Channel  | valid / stall          | payload
// ---------+------------------------+------------------------------
// input    | in_valid_i / in_stall_o  | in_item_i  (op, data_byte)
// output   | out_valid_o / out_stall_i| out_item_o (out_byte, status)
// config   | APB write/read, pready always high
//
// Feed, restart and unused ops pass from S_IDLE through S_OUT. A pull pops
// each stacked byte (skipped or delivered) in S_POP and S_CHK, decodes each
// code in S_POP, S_CHK and S_FIN plus S_WAIT and S_WALK per dictionary link
// walked, and takes a clear code in S_POP alone; the registered read ports of
// the memories set these steps. Reset leaves the dictionary undefined and the
// stack empty. The input stalls while a result waits in the output register.
module lzw_variable_width_decoder_unit #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned STACK_DEPTH   = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lzwd_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lzwd_pkg::out_item_t      out_item_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned TSIZE = 1 << MAX_CODE_BITS;
  localparam int unsigned CW    = MAX_CODE_BITS;
  localparam int unsigned SAW   = $clog2(STACK_DEPTH);
  localparam int unsigned STW   = SAW + 1;
  localparam int unsigned NEW   = CW + 1;
  localparam int unsigned WW    = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned BW    = MAX_CODE_BITS + 16;
  localparam int unsigned BCW   = $clog2(BW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_CHK, S_WALK, S_WAIT, S_FIN, S_OUT
  } state_e;

  // configuration
  logic [31:0] out_limit_q, skip_count_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q  <= '0;
      skip_count_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == lzwd_pkg::REG_OUT_LIMIT) out_limit_q <= pwdata;
      else                                    skip_count_q <= pwdata;
    end
  end
  assign prdata = (paddr[2] == lzwd_pkg::REG_OUT_LIMIT) ? out_limit_q : skip_count_q;

  // memories
  logic [CW-1:0] prefix_mem [TSIZE];
  logic [7:0]    suffix_mem [TSIZE];
  logic [7:0]    stack_mem  [STACK_DEPTH];
  logic [CW-1:0] pre_rd_q;
  logic [7:0]    suf_rd_q, stk_rd_q;
  logic          dwe, swe;
  logic [CW-1:0] dw_addr, dr_addr;
  logic [CW-1:0] dw_pre;
  logic [7:0]    dw_suf;
  logic [SAW-1:0] sw_addr, sr_addr;
  logic [7:0]    sw_data;

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      prefix_mem[dw_addr] <= dw_pre;
      suffix_mem[dw_addr] <= dw_suf;
    end
    pre_rd_q <= prefix_mem[dr_addr];
    suf_rd_q <= suffix_mem[dr_addr];
  end
  always_ff @(posedge clk_i) begin
    if (swe) stack_mem[sw_addr] <= sw_data;
    stk_rd_q <= stack_mem[sr_addr];
  end

  // state
  state_e          state_q;
  logic [STW-1:0]  top_q;
  logic [WW-1:0]   width_q;
  logic [NEW-1:0]  next_q, slot_q;
  logic [CW-1:0]   prev_q, code_q, w_q;
  logic [7:0]      first_q;
  logic [BW-1:0]   buf_q;
  logic [BCW-1:0]  cnt_q;
  logic [31:0]     dec_q, del_q;
  logic            done_q, wr_q;
  logic            ov_q;
  lzwd_pkg::out_item_t res_q;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_o;
  assign out_item_o  = res_q;

  logic [CW-1:0] code_c;
  logic [BW-1:0] wmask;
  always_comb begin
    wmask  = (BW'(1) << width_q) - BW'(1);
    code_c = CW'(buf_q & wmask);
  end

  // memory port control
  always_comb begin
    dwe = 1'b0; dw_addr = slot_q[CW-1:0]; dw_pre = prev_q; dw_suf = first_q;
    dr_addr = w_q;
    swe = 1'b0; sw_addr = top_q[SAW-1:0]; sw_data = suf_rd_q;
    sr_addr = SAW'(top_q - STW'(1));
    unique case (state_q)
      S_WALK: begin
        swe = 1'b1;
      end
      S_FIN: begin
        swe = 1'b1;
        sw_data = w_q[7:0];
        dwe = wr_q;
        dw_suf = w_q[7:0];
      end
      S_CHK: dwe = wr_q && !ov_q;
      default: ;
    endcase
  end

  logic [31:0] dec_inc;
  assign dec_inc = (dec_q == 32'hffff_ffff) ? dec_q : dec_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; top_q <= '0; width_q <= WW'(lzwd_pkg::FIRST_WIDTH);
      next_q <= NEW'(lzwd_pkg::CODE_CLEAR); prev_q <= '0; first_q <= '0;
      buf_q <= '0; cnt_q <= '0; dec_q <= '0; del_q <= '0; done_q <= 1'b0;
      out_valid_o <= 1'b0; res_q <= '0; slot_q <= '0; code_q <= '0;
      w_q <= '0; wr_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      // result register: raised on leaving S_OUT, dropped on transfer
      if (state_q == S_OUT) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && !out_valid_o) begin
          res_q <= '0;
          unique case (in_item_i.op)
            lzwd_pkg::OP_FEED: begin
              state_q <= S_OUT;
              if (done_q) res_q.status <= lzwd_pkg::ST_DONE;
              else if (cnt_q > BCW'(16)) res_q.status <= lzwd_pkg::ST_REFUSED;
              else begin
                buf_q <= buf_q | (BW'(in_item_i.data_byte) << cnt_q);
                cnt_q <= cnt_q + BCW'(8);
                res_q.status <= lzwd_pkg::ST_ACCEPTED;
              end
            end
            lzwd_pkg::OP_PULL: state_q <= S_POP;
            lzwd_pkg::OP_RESTART: begin
              top_q <= '0; prev_q <= '0; first_q <= '0; buf_q <= '0; cnt_q <= '0;
              dec_q <= '0; del_q <= '0; done_q <= 1'b0;
              width_q <= WW'(lzwd_pkg::FIRST_WIDTH);
              next_q <= NEW'(lzwd_pkg::CODE_CLEAR);
              res_q.status <= lzwd_pkg::ST_NEED; state_q <= S_OUT;
            end
            default: begin res_q.status <= lzwd_pkg::ST_NEED; state_q <= S_OUT; end
          endcase
        end
        // one step of the pull loop; pop read issued here lands next cycle
        S_POP: begin
          if (done_q) begin
            res_q.status <= lzwd_pkg::ST_DONE; state_q <= S_OUT;
          end else if (top_q != '0) begin
            top_q <= top_q - STW'(1); state_q <= S_CHK; ov_q <= 1'b1;
          end else if (BCW'(cnt_q) >= BCW'(width_q)) begin
            buf_q <= buf_q >> width_q;
            cnt_q <= cnt_q - BCW'(width_q);
            ov_q <= 1'b0;
            if (NEW'(code_c) == NEW'(lzwd_pkg::CODE_END)) begin
              done_q <= 1'b1; res_q.status <= lzwd_pkg::ST_DONE; state_q <= S_OUT;
            end else if (NEW'(code_c) == NEW'(lzwd_pkg::CODE_CLEAR)) begin
              width_q <= WW'(lzwd_pkg::FIRST_WIDTH);
              next_q <= NEW'(lzwd_pkg::CODE_CLEAR);
            end else begin
              // partial entry is written in S_CHK (suffix fixed up at FIN)
              slot_q <= next_q;
              wr_q <= (next_q < NEW'(TSIZE));
              code_q <= code_c; w_q <= code_c;
              state_q <= S_CHK;
            end
          end else begin
            res_q.status <= lzwd_pkg::ST_NEED; state_q <= S_OUT;
          end
        end
        S_CHK: begin
          if (ov_q) begin
            // popped byte available
            dec_q <= dec_inc;
            if (dec_q < skip_count_q) state_q <= S_POP;
            else if (out_limit_q == '0 || del_q != out_limit_q) begin
              del_q <= del_q + 32'd1;
              res_q.out_byte <= {stk_rd_q[2:0], stk_rd_q[7:3]};
              res_q.status <= lzwd_pkg::ST_BYTE; state_q <= S_OUT;
            end else begin
              done_q <= 1'b1; res_q.status <= lzwd_pkg::ST_DONE; state_q <= S_OUT;
            end
          end else begin
            // entry (prefix) written this cycle; start walk
            if (w_q > CW'(255) && top_q < STW'(STACK_DEPTH - 1)) state_q <= S_WAIT;
            else state_q <= S_FIN;
          end
        end
        // dictionary read of w_q in flight
        S_WAIT: state_q <= S_WALK;
        S_WALK: begin
          top_q <= top_q + STW'(1);
          w_q <= pre_rd_q;
          if (pre_rd_q > CW'(255) && (top_q + STW'(1)) < STW'(STACK_DEPTH - 1))
            state_q <= S_WAIT;
          else state_q <= S_FIN;
        end
        // prefix of the entry still needs the old previous code this cycle
        S_FIN: begin
          first_q <= w_q[7:0];
          prev_q <= code_q;
          top_q <= top_q + STW'(1);
          if (next_q < NEW'(TSIZE)) begin
            next_q <= next_q + NEW'(1);
            if (slot_q != NEW'(lzwd_pkg::CODE_CLEAR) && width_q < WW'(MAX_CODE_BITS) &&
                (next_q + NEW'(1)) >= (NEW'(1) << width_q))
              width_q <= width_q + WW'(1);
          end else if (slot_q != NEW'(lzwd_pkg::CODE_CLEAR) &&
                       width_q < WW'(MAX_CODE_BITS) && next_q >= (NEW'(1) << width_q))
            width_q <= width_q + WW'(1);
          state_q <= S_POP;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= STW'(STACK_DEPTH)) else $error("stack overflow");
  a_width_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= WW'(lzwd_pkg::FIRST_WIDTH) && width_q <= WW'(MAX_CODE_BITS))
    else $error("code width out of range");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("input taken while busy");
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && state_q == S_POP |=> res_q.status == lzwd_pkg::ST_DONE)
    else $error("finished stream produced data");

endmodule
